// File: rtl/sts_pkg.sv
// Shared types and constants for the sorted table range search block.
package sts_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned IDX_W           = 10;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned CNT_W           = 11;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] query_value;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
  } res_t;

  // Classified item handed from the front end to the search engine.
  typedef struct packed {
    logic                    is_query;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_head_t;

endpackage

// File: rtl/sts_front.sv
// Front end: accepts items, classifies them and buffers them in a short queue.
module sts_front #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  sts_pkg::cmd_t       cmd_i,
  output sts_pkg::queue_head_t head_o,
  input  logic                pop_i
);

  localparam int unsigned QD  = sts_pkg::QUEUE_DEPTH;
  localparam int unsigned PW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned FW  = $clog2(QD + 1);

  sts_pkg::queue_item_t queue_q [QD];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FW-1:0] fill_q;
  logic          full, keep, push, pop;
  sts_pkg::queue_item_t item;

  assign full = (32'(fill_q) == QD);
  assign busy = full;

  // Writes beyond the table are dropped here.
  assign keep = (cmd_i.operation == sts_pkg::OP_QUERY) ||
                (32'(cmd_i.entry_index) < TABLE_DEPTH);
  assign push = start && !full && keep;
  assign pop  = pop_i && (fill_q != '0);

  always_comb begin
    item.is_query = (cmd_i.operation == sts_pkg::OP_QUERY);
    item.index    = cmd_i.entry_index;
    item.value    = item.is_query ? cmd_i.query_value : cmd_i.entry_value;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QD - 1) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QD - 1) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + FW'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - FW'(1);
      end
    end
  end

  assign head_o.valid = (fill_q != '0);
  assign head_o.item  = queue_q[rd_ptr_q];

endmodule

// File: rtl/sts_back.sv
// Back end: table memory and the lower/upper bound binary search engine.
module sts_back #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sts_pkg::queue_head_t        head_i,
  output logic                        pop_o,
  input  logic [sts_pkg::CNT_W-1:0]   entry_count_i,
  output sts_pkg::res_t               res_o,
  output logic                        res_strobe_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_CHK   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic signed [sts_pkg::VAL_W-1:0] mem_q [TABLE_DEPTH];
  logic signed [sts_pkg::VAL_W-1:0] rd_data_q;
  logic signed [sts_pkg::VAL_W-1:0] key_q;
  logic [CW-1:0] lo_q, hi_q, n_q, mid_q, lb_q, mid, n_sat, last;
  logic          upper_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en, go_right;
  sts_pkg::res_t res_q;
  logic          strobe_q;

  assign n_sat = (32'(entry_count_i) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entry_count_i);
  assign mid   = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_addr = (state_q == ST_PROBE && lo_q < hi_q) ? mid[AW-1:0] : lo_q[AW-1:0];
  assign wr_addr = AW'(32'(head_i.item.index));
  assign wr_en   = (state_q == ST_IDLE) && head_i.valid && !head_i.item.is_query;
  assign pop_o   = (state_q == ST_IDLE) && head_i.valid;
  assign go_right = upper_q ? (rd_data_q <= key_q) : (rd_data_q < key_q);
  assign last     = (lo_q > lb_q) ? lo_q - CW'(1) : lb_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= head_i.item.value;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid && head_i.item.is_query) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (lo_q < hi_q) begin
          state_d = ST_CMP;
        end else if (!upper_q && lo_q < n_q) begin
          state_d = ST_CHK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CMP:  state_d = ST_PROBE;
      ST_CHK:  state_d = (rd_data_q == key_q) ? ST_PROBE : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= ((state_q == ST_PROBE) && !(lo_q < hi_q) &&
                   (upper_q || !(lo_q < n_q))) ||
                  ((state_q == ST_CHK) && (rd_data_q != key_q));
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        key_q   <= head_i.item.value;
        n_q     <= n_sat;
        lo_q    <= '0;
        hi_q    <= n_sat;
        upper_q <= 1'b0;
      end
      ST_PROBE: begin
        mid_q <= mid;
        if (!(lo_q < hi_q)) begin
          if (upper_q) begin
            res_q.found       <= 1'b1;
            res_q.first_index <= sts_pkg::IDX_W'(lb_q);
            res_q.last_index  <= sts_pkg::IDX_W'(last);
          end else begin
            lb_q <= lo_q;
            res_q <= '0;
          end
        end
      end
      ST_CMP: begin
        if (go_right) begin
          lo_q <= mid_q + CW'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      ST_CHK: begin
        upper_q <= 1'b1;
        lo_q    <= '0;
        hi_q    <= n_q;
        res_q   <= '0;
      end
      default: begin
      end
    endcase
  end

  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

endmodule

// File: rtl/sorted_table_range_search.sv
// Top level of the sorted table range search block.
//
// Items enter on cmd_i and are taken at a clock edge with start high and busy
// low. A write item stores entry_value at entry_index and gives no result; a
// query item gives one result on res_o, marked by res_strobe_o for exactly one
// cycle. The receiver cannot stall, so results are never held back.
// Items wait in a two-item queue; busy is high while that queue is full.
// The search engine takes one item at a time from the queue; a write goes
// straight into the table. A query starts, then runs each of the two bound
// searches as up to k = ceil(log2(n+1)) probes (one memory read, one compare)
// plus a finishing step, with n entries in use, and one check read between
// them; the upper search runs only if the check finds the key. The single
// table read port makes the probes sequential. The result is registered.
// entry_count is written over the cfg channel, which is always ready; write it
// only while no item is pending. Reset clears entry_count and the queue; the
// table content is undefined until written, and no clearing pass is done.
module sorted_table_range_search #(
  parameter int unsigned TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  sts_pkg::cmd_t             cmd_i,
  output sts_pkg::res_t             res_o,
  output logic                      res_strobe_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sts_pkg::CNT_W-1:0] cfg_data_i
);

  logic [sts_pkg::CNT_W-1:0] entry_count_q;
  sts_pkg::queue_head_t      head;
  logic                      pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entry_count_q <= cfg_data_i;
    end
  end

  sts_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .head_o (head),
    .pop_i  (pop)
  );

  sts_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .entry_count_i (entry_count_q),
    .res_o         (res_o),
    .res_strobe_o  (res_strobe_o)
  );

endmodule

// File: tb/tb_sorted_table_range_search.sv
`timescale 1ns / 1ps
// Testbench for sorted_table_range_search: directed table, then random phases checked by a predictor.
module tb_sorted_table_range_search;
  import sts_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_ITEMS = 80;

  typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    cmd_t             cmd;
    logic [CNT_W-1:0] count;
    bit               typed;
    res_t             want;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  cmd_t             cmd_i;
  res_t             res_o;
  logic             res_strobe_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;

  logic signed [VAL_W-1:0] shadow_entries [DEPTH];
  logic [CNT_W-1:0]        shadow_count;
  res_t                    range_q [$];
  stim_row_t               rows [$];
  int unsigned             fix_idx [$];
  logic signed [VAL_W-1:0] fix_val [$];
  int                      errors;
  int                      cycles;
  int                      queries;
  int                      writes;
  int                      settings;

  sorted_table_range_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .res_strobe_o(res_strobe_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[sorted_table_range_search] ERROR");
      $finish;
    end
  end

  // strict = 0: first entry not below key; strict = 1: first entry above key
  function automatic int unsigned bound_of(logic signed [VAL_W-1:0] key, int unsigned n,
                                           bit strict);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    bit          go_right;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      go_right = strict ? (shadow_entries[mid] <= key) : (shadow_entries[mid] < key);
      if (go_right) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic res_t predict_range(logic signed [VAL_W-1:0] key);
    res_t        r;
    int unsigned n;
    int unsigned lb;
    int unsigned ub;
    int unsigned last;
    r = '0;
    n = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
    if (n != 0) begin
      lb = bound_of(key, n, 1'b0);
      if (lb < n && shadow_entries[lb] == key) begin
        ub = bound_of(key, n, 1'b1);
        last = (ub > lb) ? ub - 1 : lb;
        r.found = 1'b1;
        r.first_index = lb[IDX_W-1:0];
        r.last_index = last[IDX_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic cmd_t make_write(int unsigned idx, logic signed [VAL_W-1:0] val);
    cmd_t c;
    c.operation = OP_WRITE;
    c.entry_index = idx[IDX_W-1:0];
    c.entry_value = val;
    c.query_value = $urandom;
    return c;
  endfunction

  function automatic cmd_t make_query(logic signed [VAL_W-1:0] val);
    cmd_t c;
    c.operation = OP_QUERY;
    c.entry_index = IDX_W'($urandom);
    c.entry_value = $urandom;
    c.query_value = val;
    return c;
  endfunction

  function automatic void add_write(int unsigned idx, logic signed [VAL_W-1:0] val);
    stim_row_t r;
    r = '{ROW_ITEM, make_write(idx, val), '0, 1'b0, '0};
    rows.push_back(r);
  endfunction

  function automatic void add_query(logic signed [VAL_W-1:0] val);
    stim_row_t r;
    r = '{ROW_ITEM, make_query(val), '0, 1'b0, '0};
    rows.push_back(r);
  endfunction

  function automatic void add_checked(logic signed [VAL_W-1:0] val, logic f, int unsigned fi,
                                      int unsigned la);
    stim_row_t r;
    r = '{ROW_ITEM, make_query(val), '0, 1'b1, '0};
    r.want.found = f;
    r.want.first_index = fi[IDX_W-1:0];
    r.want.last_index = la[IDX_W-1:0];
    rows.push_back(r);
  endfunction

  function automatic void add_count(logic [CNT_W-1:0] v);
    stim_row_t r;
    r = '{ROW_CONFIG, '0, v, 1'b0, '0};
    rows.push_back(r);
  endfunction

  task automatic send_item(cmd_t c, bit typed, res_t want);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (c.operation == OP_QUERY) begin
      range_q.push_back(typed ? want : predict_range(c.query_value));
      queries++;
    end else begin
      shadow_entries[c.entry_index] = c.entry_value;
      writes++;
    end
  endtask

  // wait for all results, then for writes still in flight
  task automatic settle();
    start <= 1'b0;
    while (range_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CNT_W-1:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shadow_count = v;
    settings++;
  endtask

  task automatic idle_gap(int pct);
    if (pct != 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < pct) @(posedge clk_i);
    end
  endtask

  task automatic random_item();
    int unsigned             n;
    int unsigned             idx;
    int unsigned             sel;
    int unsigned             d;
    longint                  lo;
    longint                  hi;
    longint                  v;
    logic signed [VAL_W-1:0] key;
    n = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
    sel = $urandom_range(99);
    if (sel < 70) begin
      idx = (n != 0) ? $urandom_range(n - 1) : $urandom_range(DEPTH - 1);
      d = $urandom_range(3);
      key = shadow_entries[idx];
      if (d == 0) key = key - 1;
      else if (d == 3) key = key + 1;
      send_item(make_query(key), 1'b0, '0);
    end else if (sel < 82) begin
      send_item(make_query($urandom), 1'b0, '0);
    end else if (sel < 95) begin
      // value between the neighbors keeps the order
      idx = $urandom_range(DEPTH - 1);
      lo = -64'sd2147483648;
      hi = 64'sd2147483647;
      if (idx > 0) lo = longint'(shadow_entries[idx - 1]);
      if (idx < DEPTH - 1) hi = longint'(shadow_entries[idx + 1]);
      v = (hi >= lo) ? lo + longint'($urandom) % (hi - lo + 1) : lo;
      send_item(make_write(idx, VAL_W'(v)), 1'b0, '0);
    end else begin
      idx = $urandom_range(DEPTH - 1);
      fix_idx.push_back(idx);
      fix_val.push_back(shadow_entries[idx]);
      send_item(make_write(idx, $urandom), 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_strobe_o) begin
      if (range_q.size() == 0) begin
        $display("%0t: unexpected result found=%0d first=%0d last=%0d", $time,
                 res_o.found, res_o.first_index, res_o.last_index);
        errors++;
      end else begin
        want = range_q.pop_front();
        if (res_o.found !== want.found)
          $display("%0t: found expected %0d got %0d", $time, want.found, res_o.found);
        if (res_o.first_index !== want.first_index)
          $display("%0t: first_index expected %0d got %0d", $time, want.first_index,
                   res_o.first_index);
        if (res_o.last_index !== want.last_index)
          $display("%0t: last_index expected %0d got %0d", $time, want.last_index,
                   res_o.last_index);
        if (res_o !== want) errors++;
      end
    end
  end

  initial begin : stimulus
    int                      counts [10];
    int                      pcts [4];
    longint                  v;
    stim_row_t               r;
    logic signed [VAL_W-1:0] run_val;
    errors = 0;
    cycles = 0;
    queries = 0;
    writes = 0;
    settings = 0;
    shadow_count = '0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_checked(32'sd0, 1'b0, 0, 0);
    add_checked(32'sh7fffffff, 1'b0, 0, 0);
    add_write(0, 32'sh80000000);
    add_write(1, -32'sd5);
    add_write(2, -32'sd5);
    add_write(3, -32'sd5);
    add_write(4, 32'sd0);
    add_write(5, 32'sd7);
    add_write(6, 32'sd7);
    add_write(7, 32'sh7fffffff);
    add_count(11'd8);
    add_checked(32'sh80000000, 1'b1, 0, 0);
    add_query(-32'sd5);
    add_query(32'sd7);
    add_checked(32'sh7fffffff, 1'b1, 7, 7);
    add_checked(32'sd3, 1'b0, 0, 0);
    add_checked(32'sh80000001, 1'b0, 0, 0);
    add_query(32'sd0);
    add_write(1023, -32'sd1);
    add_write(2, 32'sd100);
    add_query(-32'sd5);
    add_query(32'sd100);
    add_count(11'd0);
    add_checked(-32'sd5, 1'b0, 0, 0);
    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == ROW_CONFIG) write_count(r.count);
      else send_item(r.cmd, r.typed, r.want);
    end

    // ascending fill with runs of equal values
    v = -64'sd2147483648;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: v = v;
        9:          v = v + $urandom_range(40000000, 1);
        default:    v = v + $urandom_range(1000, 1);
      endcase
      if (v > 64'sd2147483647 || i == DEPTH - 1) v = 64'sd2147483647;
      run_val = VAL_W'(v);
      idle_gap(26);
      send_item(make_write(i, run_val), 1'b0, '0);
    end

    counts = '{1024, 1, 2047, 2, 3, 1000, 1025, 0, 0, 1024};
    counts[8] = $urandom_range(1023, 4);
    pcts = '{0, 53, 0, 26};
    for (int p = 0; p < 10; p++) begin
      write_count(CNT_W'(counts[p]));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && p % 3 == 1) settle();
        else idle_gap(pcts[p % 4]);
        random_item();
      end
      while (fix_idx.size() != 0)
        send_item(make_write(fix_idx.pop_back(), fix_val.pop_back()), 1'b0, '0);
    end

    settle();
    $display("run: %0d writes, %0d queries checked, %0d entry_count settings", writes,
             queries, settings);
    $display("counts covered empty, one entry, full table and saturated; sender idle 0-53%%");
    if (errors == 0) begin
      $display("[sorted_table_range_search] OK");
    end else begin
      $display("[sorted_table_range_search] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sts_pkg.sv
rtl/sts_front.sv
rtl/sts_back.sv
rtl/sorted_table_range_search.sv
tb/tb_sorted_table_range_search.sv
